// ----- sv/dual_wavetable_player_q15_defines.svh -----
// Assertion macros for the dual wavetable player checker.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef DUAL_WAVETABLE_PLAYER_Q15_DEFINES_SVH
`define DUAL_WAVETABLE_PLAYER_Q15_DEFINES_SVH

// same-cycle implication, gated by reset
`define WTP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define WTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/wtp_pkg.sv -----
// Shared constants, types and arithmetic helpers of the dual wavetable player.
// No dependencies.
`default_nettype none

package wtp_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 12;
    localparam int SMP_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int LEN_W       = 13;
    localparam int SHIFT       = 15;
    localparam int PROD_W      = SMP_W + GAIN_W + 1;
    localparam int CMP_W       = (LEN_W > ADDR_W + 1) ? LEN_W : ADDR_W + 1;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'((1 << (SMP_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] Q_MIN = ~Q_MAX;

    typedef enum logic
    {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        REG_GAIN_LEFT    = 2'd0,
        REG_GAIN_RIGHT   = 2'd1,
        REG_LENGTH_LEFT  = 2'd2,
        REG_LENGTH_RIGHT = 2'd3
    } reg_idx_t;

    // per-channel control from the top level
    typedef struct packed
    {
        logic              tick;
        logic              wr;
        logic [ADDR_W-1:0] wr_addr;
        logic [SMP_W-1:0]  wr_data;
        logic              len_wr;
        logic              en2;
    } wtp_ctrl_t;

    // floor shift by SHIFT, then clamp to the sample range
    function automatic logic [SMP_W-1:0] scale_sat(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W-1:0] c;
        q = prod >>> SHIFT;
        if (q > Q_MAX)
        begin
            c = Q_MAX;
        end
        else if (q < Q_MIN)
        begin
            c = Q_MIN;
        end
        else
        begin
            c = q;
        end
        return c[SMP_W-1:0];
    endfunction

    // advance and wrap; a length of 0 acts as 1, above the depth as the depth
    function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] pos,
                                                   input logic [LEN_W-1:0]  len);
        logic [CMP_W-1:0] n;
        logic [CMP_W-1:0] eff;
        n = CMP_W'(pos) + CMP_W'(1);
        if (len == '0)
        begin
            eff = CMP_W'(1);
        end
        else if (CMP_W'(len) > CMP_W'(TABLE_DEPTH))
        begin
            eff = CMP_W'(TABLE_DEPTH);
        end
        else
        begin
            eff = CMP_W'(len);
        end
        return (n >= eff) ? '0 : n[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/wtp_if.sv -----
// Valid/ready channel interfaces: input items and stereo output frames.
// Depends on wtp_pkg for field widths.
`default_nettype none

interface wtp_in_if;
    import wtp_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic             channel;
    logic [IDX_W-1:0] index;
    logic [SMP_W-1:0] sample;

    modport source (output valid, output func, output channel, output index,
                    output sample, input ready);
    modport sink   (input valid, input func, input channel, input index,
                    input sample, output ready);
endinterface

interface wtp_out_if;
    import wtp_pkg::*;

    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] left_out;
    logic [SMP_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ----- sv/wtp_chan.sv -----
// One channel: sample table memory, loop position, gain multiply.
// Depends on wtp_pkg.
`default_nettype none

module wtp_chan
    import wtp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wtp_ctrl_t         ctrl,
    input  wire logic [GAIN_W-1:0] gain,
    input  wire logic [LEN_W-1:0]  length,
    output      logic [SMP_W-1:0]  scaled
);

    logic [SMP_W-1:0]         table_mem [TABLE_DEPTH];
    logic [SMP_W-1:0]         rdata_reg;
    logic [ADDR_W-1:0]        pos_reg;
    logic [ADDR_W-1:0]        pos_next;
    logic signed [PROD_W-1:0] prod_reg;

    // one write or one read per cycle; a write is seen by the next tick's read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            table_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.tick)
        begin
            rdata_reg <= table_mem[pos_reg];
        end
    end

    assign pos_next = next_pos(pos_reg, length);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (ctrl.len_wr)
        begin
            pos_reg <= '0;
        end
        else if (ctrl.tick)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en2)
        begin
            prod_reg <= $signed(rdata_reg) * $signed({1'b0, gain});
        end
    end

    assign scaled = scale_sat(prod_reg);

endmodule

`default_nettype wire

// ----- sv/dual_wavetable_player_q15.sv -----
// Two-channel looping wavetable player. Write items load one entry of the left or right
// sample table; tick items read both tables at their loop positions, scale each sample by
// its Q15 gain (floor shift by 15, clamped) and return one stereo frame. One item is taken
// every cycle unless stalled; a frame passes the table read, multiply and output register
// stages, and the pipeline keeps taking items while a frame waits, stalling only when all
// three stages hold data. Tables hold no reset value and need no clearing pass. Writing a
// length register restarts that channel at entry 0. Depends on wtp_pkg, wtp_if.
`default_nettype none

module dual_wavetable_player_q15
    import wtp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wtp_in_if.sink                     items,
    wtp_out_if.source                  frames,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    logic [GAIN_W-1:0] gain_l_reg;
    logic [GAIN_W-1:0] gain_r_reg;
    logic [LEN_W-1:0]  len_l_reg;
    logic [LEN_W-1:0]  len_r_reg;
    logic              cfg_wr;
    reg_idx_t          reg_idx;

    logic              v1_reg;
    logic              v2_reg;
    logic              vo_reg;
    logic              en1;
    logic              en2;
    logic              en_out;
    logic              acc;
    logic              tick;
    logic              wr_ok;
    logic [SMP_W-1:0]  left_reg;
    logic [SMP_W-1:0]  right_reg;
    logic [SMP_W-1:0]  scaled_l;
    logic [SMP_W-1:0]  scaled_r;
    wtp_ctrl_t         ctrl_l;
    wtp_ctrl_t         ctrl_r;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_l_reg <= '0;
            gain_r_reg <= '0;
            len_l_reg  <= LEN_W'(1);
            len_r_reg  <= LEN_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_GAIN_LEFT:    gain_l_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_RIGHT:   gain_r_reg <= pwdata[GAIN_W-1:0];
                REG_LENGTH_LEFT:  len_l_reg  <= pwdata[LEN_W-1:0];
                REG_LENGTH_RIGHT: len_r_reg  <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAIN_LEFT:    prdata = APB_DATA_W'(gain_l_reg);
            REG_GAIN_RIGHT:   prdata = APB_DATA_W'(gain_r_reg);
            REG_LENGTH_LEFT:  prdata = APB_DATA_W'(len_l_reg);
            REG_LENGTH_RIGHT: prdata = APB_DATA_W'(len_r_reg);
            default:          prdata = '0;
        endcase
    end

    // each stage moves when the one after it is empty or moving
    assign en_out      = !vo_reg || frames.ready;
    assign en2         = !v2_reg || en_out;
    assign en1         = !v1_reg || en2;
    assign items.ready = en1;

    assign acc   = items.valid && en1;
    assign tick  = acc && (items.func == FUNC_TICK);
    assign wr_ok = acc && (items.func == FUNC_WRITE)
                   && (CMP_W'(items.index) < CMP_W'(TABLE_DEPTH));

    always_comb
    begin
        ctrl_l.tick    = tick;
        ctrl_l.wr      = wr_ok && !items.channel;
        ctrl_l.wr_addr = ADDR_W'(items.index);
        ctrl_l.wr_data = items.sample;
        ctrl_l.len_wr  = cfg_wr && (reg_idx == REG_LENGTH_LEFT);
        ctrl_l.en2     = en2;

        ctrl_r         = ctrl_l;
        ctrl_r.wr      = wr_ok && items.channel;
        ctrl_r.len_wr  = cfg_wr && (reg_idx == REG_LENGTH_RIGHT);
    end

    wtp_chan u_chan_l
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl_l),
        .gain   (gain_l_reg),
        .length (len_l_reg),
        .scaled (scaled_l)
    );

    wtp_chan u_chan_r
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl_r),
        .gain   (gain_r_reg),
        .length (len_r_reg),
        .scaled (scaled_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= tick;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en_out)
            begin
                vo_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && v2_reg)
        begin
            left_reg  <= scaled_l;
            right_reg <= scaled_r;
        end
    end

    assign frames.valid     = vo_reg;
    assign frames.left_out  = left_reg;
    assign frames.right_out = right_reg;

endmodule

`default_nettype wire

// ----- sv/wtp_checker.sv -----
// Port-level checker for the dual wavetable player, bound to the top level.
// Depends on dual_wavetable_player_q15_defines.svh and wtp_pkg.
`default_nettype none
`include "dual_wavetable_player_q15_defines.svh"

module wtp_checker
    import wtp_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             items_valid,
    input wire logic             items_ready,
    input wire logic             items_func,
    input wire logic             frames_valid,
    input wire logic             frames_ready,
    input wire logic [SMP_W-1:0] frames_left,
    input wire logic [SMP_W-1:0] frames_right
);

    // a stalled frame transaction keeps its payload
    `WTP_ASSERT_NEXT(a_frame_hold, frames_valid && !frames_ready, frames_valid && $stable(frames_left) && $stable(frames_right), "frame changed while stalled")

    // with no frame waiting the pipeline cannot be full
    `WTP_ASSERT_IMPL(a_ready_when_empty, !frames_valid, items_ready, "input stalled with empty output")

    // an accepted tick yields a valid frame when the sink keeps up
    `WTP_ASSERT_NEXT(a_tick_latency, items_valid && items_ready && (items_func == FUNC_TICK) ##1 frames_ready ##1 frames_ready, frames_valid, "frame missing three cycles after tick")

endmodule

bind dual_wavetable_player_q15 wtp_checker u_wtp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .items_valid  (items.valid),
    .items_ready  (items.ready),
    .items_func   (items.func),
    .frames_valid (frames.valid),
    .frames_ready (frames.ready),
    .frames_left  (frames.left_out),
    .frames_right (frames.right_out)
);

`default_nettype wire

// ----- tb/dual_wavetable_player_q15_tb.sv -----
// Self-checking testbench for dual_wavetable_player_q15: directed table, then random phases.
// Depends on wtp_pkg, wtp_if and the player RTL; frames are checked against a local predictor.
`timescale 1ns / 1ps

module dual_wavetable_player_q15_tb;
    import wtp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 8;
    localparam int N_DIRECTED  = 28;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 100;

    typedef enum logic
    {
        ROW_CFG  = 1'b0,
        ROW_ITEM = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t        kind;
        reg_idx_t         rsel;
        logic [31:0]      val;
        func_t            fn;
        logic             ch;
        logic [IDX_W-1:0] idx;
        logic [SMP_W-1:0] smp;
        logic             typed;
        logic [SMP_W-1:0] exp_l;
        logic [SMP_W-1:0] exp_r;
    } step_t;

    typedef struct packed
    {
        logic [SMP_W-1:0] l;
        logic [SMP_W-1:0] r;
    } frame_t;

    // typed expectations only where the arithmetic is obvious
    step_t directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b0, 12'd0,   16'h7FFF, 1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b1, 12'd0,   16'h8000, 1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b1, 16'h0,    16'h0},
        '{ROW_CFG,  REG_GAIN_LEFT,    32'd32768, FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_GAIN_RIGHT,   32'd32768, FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b1, 16'h7FFF, 16'h8000},
        '{ROW_CFG,  REG_GAIN_LEFT,    32'd65535, FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_GAIN_RIGHT,   32'd65535, FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b1, 12'hFFF, 16'hFFFF, 1'b1, 16'h7FFF, 16'h8000},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b0, 12'd0,   16'hFFFF, 1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b1, 12'd0,   16'h0001, 1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_GAIN_LEFT,    32'd1,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_GAIN_RIGHT,   32'd1,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b1, 16'hFFFF, 16'h0000},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b0, 12'hFFF, 16'h1234, 1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b1, 12'hFFF, 16'hEDCB, 1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_LENGTH_LEFT,  32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_LENGTH_RIGHT, 32'd8191,  FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_GAIN_LEFT,    32'h5A5A,  FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_GAIN_RIGHT,   32'hA5A5,  FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b1, 12'd1,   16'h4000, 1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_LENGTH_LEFT,  32'd4097,  FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  REG_LENGTH_RIGHT, 32'd2,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_WRITE, 1'b0, 12'd1,   16'h0F0F, 1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_ITEM, REG_GAIN_LEFT,    32'd0,     FUNC_TICK,  1'b0, 12'd0,   16'h0,    1'b0, 16'h0,    16'h0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    wtp_in_if  in_ch ();
    wtp_out_if out_ch ();

    dual_wavetable_player_q15 u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (in_ch),
        .frames  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [SMP_W-1:0]  left_tbl  [TABLE_DEPTH];
    logic [SMP_W-1:0]  right_tbl [TABLE_DEPTH];
    bit                left_set  [TABLE_DEPTH];
    bit                right_set [TABLE_DEPTH];
    logic [ADDR_W-1:0] pos_l;
    logic [ADDR_W-1:0] pos_r;
    logic [GAIN_W-1:0] gain_l;
    logic [GAIN_W-1:0] gain_r;
    logic [LEN_W-1:0]  len_l;
    logic [LEN_W-1:0]  len_r;

    frame_t frames_due [$];
    int     errors;
    int     cycle_count;
    bit     steady;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic int loop_len(logic [LEN_W-1:0] len);
        if (len == '0)
        begin
            return 1;
        end
        else if (int'(len) > TABLE_DEPTH)
        begin
            return TABLE_DEPTH;
        end
        return int'(len);
    endfunction

    function automatic logic [ADDR_W-1:0] step_pos(logic [ADDR_W-1:0] pos, logic [LEN_W-1:0] len);
        int n;
        n = int'(pos) + 1;
        return (n >= loop_len(len)) ? '0 : ADDR_W'(n);
    endfunction

    // Q15 gain with floor rounding, clamped to the 16-bit range
    function automatic logic [SMP_W-1:0] apply_gain(logic [SMP_W-1:0] raw, logic [GAIN_W-1:0] g);
        longint p;
        longint gl;
        p  = longint'($signed(raw));
        gl = longint'(g);
        p  = (p * gl) >>> SHIFT;
        if (p > 32767)
        begin
            p = 32767;
        end
        else if (p < -32768)
        begin
            p = -32768;
        end
        return p[SMP_W-1:0];
    endfunction

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // advance the player by one accepted transaction
    function automatic void play_item(func_t fn, logic ch, logic [IDX_W-1:0] idx,
                                      logic [SMP_W-1:0] smp, logic typed,
                                      logic [SMP_W-1:0] el, logic [SMP_W-1:0] er);
        frame_t f;
        if (fn == FUNC_WRITE)
        begin
            if (ch)
            begin
                right_tbl[idx] = smp;
                right_set[idx] = 1'b1;
            end
            else
            begin
                left_tbl[idx] = smp;
                left_set[idx] = 1'b1;
            end
            return;
        end
        f.l = typed ? el : apply_gain(left_tbl[pos_l], gain_l);
        f.r = typed ? er : apply_gain(right_tbl[pos_r], gain_r);
        frames_due.push_back(f);
        pos_l = step_pos(pos_l, len_l);
        pos_r = step_pos(pos_r, len_r);
    endfunction

    task automatic send_item(func_t fn, logic ch, logic [IDX_W-1:0] idx, logic [SMP_W-1:0] smp,
                             logic typed, logic [SMP_W-1:0] el, logic [SMP_W-1:0] er);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.func    <= fn;
        in_ch.channel <= ch;
        in_ch.index   <= idx;
        in_ch.sample  <= smp;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        play_item(fn, ch, idx, smp, typed, el, er);
    endtask

    // hold the sender until every frame is back and the pipeline has emptied
    task automatic settle_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic reg_write(reg_idx_t r, logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({r, 2'b00});
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (r)
            REG_GAIN_LEFT:    gain_l = v[GAIN_W-1:0];
            REG_GAIN_RIGHT:   gain_r = v[GAIN_W-1:0];
            REG_LENGTH_LEFT:
            begin
                len_l = v[LEN_W-1:0];
                pos_l = '0;
            end
            REG_LENGTH_RIGHT:
            begin
                len_r = v[LEN_W-1:0];
                pos_r = '0;
            end
            default: ;
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== v)
        begin
            flag_error($sformatf("register %s read back %0h, wrote %0h", r.name(), prdata, v));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd32768;
            2:       return 32'd65535;
            3:       return 32'd1;
            default: return 32'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd4096;
            2:       return 32'd8191;
            3:       return 32'($urandom_range(4097, 8191));
            4:       return 32'($urandom_range(1, 4096));
            default: return 32'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // one random transaction; a tick only goes out once both read entries hold data
    task automatic random_item();
        logic             ch;
        logic [IDX_W-1:0] idx;
        if ($urandom_range(0, 99) < 60)
        begin
            if (!left_set[pos_l])
            begin
                send_item(FUNC_WRITE, 1'b0, pos_l, pick_sample(), 1'b0, '0, '0);
            end
            else if (!right_set[pos_r])
            begin
                send_item(FUNC_WRITE, 1'b1, pos_r, pick_sample(), 1'b0, '0, '0);
            end
            else
            begin
                send_item(FUNC_TICK, 1'($urandom), 12'($urandom), 16'($urandom), 1'b0, '0, '0);
            end
        end
        else
        begin
            ch = 1'($urandom);
            if ($urandom_range(0, 4) == 0)
            begin
                idx = 12'($urandom);
            end
            else
            begin
                idx = 12'($urandom_range(0, loop_len(ch ? len_r : len_l) - 1));
            end
            send_item(FUNC_WRITE, ch, idx, pick_sample(), 1'b0, '0, '0);
        end
    endtask

    // receiver: random back-pressure, off during steady phases
    initial
    begin
        int hold;
        hold         = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    hold = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (frames_due.size() == 0)
            begin
                flag_error($sformatf("frame with nothing pending: L=%0d R=%0d",
                                     $signed(out_ch.left_out), $signed(out_ch.right_out)));
            end
            else
            begin
                want = frames_due.pop_front();
                if (out_ch.left_out !== want.l || out_ch.right_out !== want.r)
                begin
                    flag_error($sformatf("frame mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                         $signed(want.l), $signed(want.r),
                                         $signed(out_ch.left_out), $signed(out_ch.right_out)));
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_TICK;
        in_ch.channel = 1'b0;
        in_ch.index   = '0;
        in_ch.sample  = '0;
        errors        = 0;
        cycle_count   = 0;
        steady        = 1'b0;
        pos_l         = '0;
        pos_r         = '0;
        gain_l        = '0;
        gain_r        = '0;
        len_l         = LEN_W'(1);
        len_r         = LEN_W'(1);
        foreach (left_set[i])
        begin
            left_set[i]  = 1'b0;
            right_set[i] = 1'b0;
            left_tbl[i]  = '0;
            right_tbl[i] = '0;
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle_idle();
                reg_write(directed_rows[i].rsel, directed_rows[i].val);
            end
            else
            begin
                send_item(directed_rows[i].fn, directed_rows[i].ch, directed_rows[i].idx,
                          directed_rows[i].smp, directed_rows[i].typed,
                          directed_rows[i].exp_l, directed_rows[i].exp_r);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle_idle();
            steady = (ph % 4 == 3);
            if ($urandom_range(0, 1))
            begin
                reg_write(REG_GAIN_LEFT, pick_gain());
            end
            if ($urandom_range(0, 1))
            begin
                reg_write(REG_GAIN_RIGHT, pick_gain());
            end
            if ($urandom_range(0, 1))
            begin
                reg_write(REG_LENGTH_LEFT, pick_length());
            end
            if ($urandom_range(0, 1))
            begin
                reg_write(REG_LENGTH_RIGHT, pick_length());
            end
            repeat (PHASE_ITEMS) random_item();
        end

        steady = 1'b0;
        settle_idle();
        if (frames_due.size() != 0)
        begin
            flag_error("frames still pending at the end");
        end
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
